// ===== rtl/core/ldm_pkg.sv =====
// Shared constants and helper functions for the lattice decimal multiplier.
`timescale 1ns / 1ps

package ldm_pkg;

	// Default number of decimal digits per operand magnitude
	localparam int OPERAND_DIGITS_DEF = 8;

	// Operand field and magnitude widths
	localparam int OPERAND_W = 28;
	localparam int MAG_W     = 28;
	localparam int DIGIT_W   = 4;

	// Divide-by-ten reciprocal: q = (v * RECIP10) >> RECIP_SHIFT, exact below 2^32
	localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;
	localparam int          PROD_W      = MAG_W + 32;
	localparam int          QUO_W       = PROD_W - RECIP_SHIFT;

	// Largest magnitude that fits in the given number of decimal digits
	function automatic logic [63:0] dec_limit(input int digits);
		logic [63:0] p;
		p = 64'd1;
		for (int n = 0; n < digits; n++) begin
			p = p * 64'd10;
		end
		return p - 64'd1;
	endfunction

	// Split a digit product into {tens, units}; p/10 as (p*205)>>11, exact for p < 1029
	function automatic logic [7:0] lattice_split(input logic [3:0] a, input logic [3:0] b);
		logic [6:0]  p;
		logic [14:0] scaled;
		logic [3:0]  tens;
		logic [6:0]  tens_x10;
		logic [3:0]  units;
		p        = 7'(a) * 7'(b);
		scaled   = 15'(p) * 15'd205;
		tens     = scaled[14:11];
		tens_x10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
		units    = 4'(p - tens_x10);
		return {tens, units};
	endfunction

endpackage

// ===== rtl/core/ldm_div10.sv =====
// Shared divide-by-ten unit: reciprocal multiply, registered, quotient and remainder out.
`timescale 1ns / 1ps

module ldm_div10 (
	input  logic                          clk,
	input  logic                          load,
	input  logic [ldm_pkg::MAG_W-1:0]     din,
	output logic [ldm_pkg::QUO_W-1:0]     quo,
	output logic [ldm_pkg::DIGIT_W-1:0]   rem
);

	logic [ldm_pkg::MAG_W-1:0]  val_q;
	logic [ldm_pkg::PROD_W-1:0] prod_q;
	logic [ldm_pkg::DIGIT_W-1:0] quo_x10_lo;

	// Capture the dividend and its reciprocal product
	always_ff @(posedge clk) begin
		if (load) begin
			val_q  <= din;
			prod_q <= ldm_pkg::PROD_W'(din) * ldm_pkg::PROD_W'(ldm_pkg::RECIP10);
		end
	end

	// Quotient from the product, remainder in mod-16 arithmetic since it stays below ten
	assign quo        = prod_q[ldm_pkg::PROD_W-1:ldm_pkg::RECIP_SHIFT];
	assign quo_x10_lo = ldm_pkg::DIGIT_W'({quo, 3'b000}) + ldm_pkg::DIGIT_W'({quo, 1'b0});
	assign rem        = val_q[ldm_pkg::DIGIT_W-1:0] - quo_x10_lo;

endmodule

// ===== rtl/core/lattice_decimal_multiplier_core.sv =====
// Top level of the lattice decimal multiplier: sequencer, digit stores and result memory.
`timescale 1ns / 1ps

// Multiplies two signed 28-bit operands and delivers the product as decimal digits, most
// significant first, one word per strobe; the receiver cannot stall, so every strobed word
// must be taken in its cycle. An operation is accepted when start is high and busy is low,
// and busy stays high until the last digit read is issued. The shared divide-by-ten unit
// first splits each operand into digits; then, column by column, one lattice digit product
// is summed per cycle and the column's decimal carry is resolved through the same unit in
// the RLOAD and RES states; the result memory then gives out one word per cycle.
// Magnitudes above OPERAND_DIGITS nines saturate.
module lattice_decimal_multiplier_core #(
	parameter int OPERAND_DIGITS = ldm_pkg::OPERAND_DIGITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [ldm_pkg::OPERAND_W-1:0] multiplicand,
	input  logic signed [ldm_pkg::OPERAND_W-1:0] multiplier,
	output logic                                strobe,
	output logic [ldm_pkg::DIGIT_W-1:0]         digit,
	output logic                                negative,
	output logic                                last_digit
);

	localparam int IW     = (OPERAND_DIGITS > 1) ? $clog2(OPERAND_DIGITS) : 1;
	localparam int CW     = $clog2(OPERAND_DIGITS + 1);
	localparam int KW     = $clog2(2 * OPERAND_DIGITS);
	localparam int NW     = KW + 1;
	localparam int TW     = $clog2(2 * OPERAND_DIGITS + 1);
	localparam int ACC_W  = $clog2(19 * OPERAND_DIGITS + 1);
	localparam int MAG_W  = ldm_pkg::MAG_W;
	localparam int DW     = ldm_pkg::DIGIT_W;
	localparam logic [63:0] MAG_LIMIT = ldm_pkg::dec_limit(OPERAND_DIGITS);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CONV  = 6'b000010,
		ST_PROD  = 6'b000100,
		ST_RLOAD = 6'b001000,
		ST_RES   = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	state_t state_q;

	// Sequencer registers
	logic              conv_b_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     na_q;
	logic [CW-1:0]     nb_q;
	logic [KW-1:0]     k_q;
	logic [IW-1:0]     i_q;
	logic [IW-1:0]     i_hi_q;
	logic [KW-1:0]     ptr_q;
	logic              strobe_q;

	// Payload registers
	logic [MAG_W-1:0]  mag_b_q;
	logic              neg_q;
	logic [ACC_W-1:0]  acc_cur_q;
	logic [ACC_W-1:0]  acc_next_q;
	logic [ACC_W-1:0]  carry_q;
	logic [DW-1:0]     rd_q;
	logic              last_q;
	logic [DW-1:0]     da_q [OPERAND_DIGITS];
	logic [DW-1:0]     db_q [OPERAND_DIGITS];
	logic [DW-1:0]     res_mem [2 * OPERAND_DIGITS];

	// Operand magnitudes, saturation and product sign
	logic              sign_a;
	logic              sign_b;
	logic [MAG_W-1:0]  mag_a;
	logic [MAG_W-1:0]  mag_b;
	logic [MAG_W-1:0]  sat_a;
	logic [MAG_W-1:0]  sat_b;

	assign sign_a = multiplicand[ldm_pkg::OPERAND_W-1];
	assign sign_b = multiplier[ldm_pkg::OPERAND_W-1];
	assign mag_a  = sign_a ? MAG_W'(~multiplicand + 1'b1) : MAG_W'(multiplicand);
	assign mag_b  = sign_b ? MAG_W'(~multiplier + 1'b1) : MAG_W'(multiplier);
	assign sat_a  = (64'(mag_a) > MAG_LIMIT) ? MAG_LIMIT[MAG_W-1:0] : mag_a;
	assign sat_b  = (64'(mag_b) > MAG_LIMIT) ? MAG_LIMIT[MAG_W-1:0] : mag_b;

	// Shared divide-by-ten unit
	logic                      div_load;
	logic [MAG_W-1:0]          div_din;
	logic [ldm_pkg::QUO_W-1:0] div_quo;
	logic [DW-1:0]             div_rem;

	ldm_div10 u_div10 (
		.clk  (clk),
		.load (div_load),
		.din  (div_din),
		.quo  (div_quo),
		.rem  (div_rem)
	);

	// Conversion step decisions
	logic [CW-1:0] cnt_inc;
	logic          conv_done;

	assign cnt_inc   = cnt_q + 1'b1;
	assign conv_done = (div_quo == '0) || (cnt_inc == CW'(OPERAND_DIGITS));

	// Column bookkeeping
	logic [TW-1:0] total;
	logic [KW-1:0] k_last;
	logic [NW-1:0] k1;
	logic [NW-1:0] lo_next;
	logic [NW-1:0] hi_next;
	logic [KW-1:0] j_idx;

	assign total   = TW'(na_q) + TW'(nb_q);
	assign k_last  = KW'(total - 1'b1);
	assign k1      = NW'(k_q) + 1'b1;
	assign lo_next = (k1 >= NW'(nb_q)) ? (k1 - NW'(nb_q) + 1'b1) : '0;
	assign hi_next = (k1 < NW'(na_q)) ? k1 : (NW'(na_q) - 1'b1);
	assign j_idx   = k_q - KW'(i_q);

	// One lattice digit product per cycle while in ST_PROD
	logic [7:0]       lattice_pair;
	logic [ACC_W-1:0] acc_cur_add;
	logic [ACC_W-1:0] acc_next_add;

	assign lattice_pair = ldm_pkg::lattice_split(da_q[i_q], db_q[j_idx[IW-1:0]]);
	assign acc_cur_add  = acc_cur_q + ACC_W'(lattice_pair[3:0]);
	assign acc_next_add = acc_next_q + ACC_W'(lattice_pair[7:4]);

	// Drive the shared unit
	always_comb begin
		div_load = 1'b0;
		div_din  = '0;
		case (state_q)
			ST_IDLE: begin
				div_load = start;
				div_din  = sat_a;
			end
			ST_CONV: begin
				div_load = 1'b1;
				div_din  = (conv_done && !conv_b_q) ? mag_b_q : MAG_W'(div_quo);
			end
			ST_RLOAD: begin
				div_load = 1'b1;
				div_din  = MAG_W'(acc_cur_q + carry_q);
			end
			default: begin
				div_load = 1'b0;
				div_din  = '0;
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			conv_b_q <= 1'b0;
			cnt_q    <= '0;
			na_q     <= CW'(1);
			nb_q     <= CW'(1);
			k_q      <= '0;
			i_q      <= '0;
			i_hi_q   <= '0;
			ptr_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (state_q == ST_EMIT);
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						conv_b_q <= 1'b0;
						cnt_q    <= '0;
						state_q  <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (!conv_done) begin
						cnt_q <= cnt_inc;
					end else if (!conv_b_q) begin
						na_q     <= cnt_inc;
						conv_b_q <= 1'b1;
						cnt_q    <= '0;
					end else begin
						nb_q    <= cnt_inc;
						k_q     <= '0;
						i_q     <= '0;
						i_hi_q  <= '0;
						state_q <= ST_PROD;
					end
				end
				ST_PROD: begin
					if (i_q == i_hi_q) begin
						state_q <= ST_RLOAD;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_RLOAD: begin
					state_q <= ST_RES;
				end
				ST_RES: begin
					if (k_q == k_last) begin
						// Single-digit operands drop a zero leading digit
						if (na_q == CW'(1) && nb_q == CW'(1) && div_rem == '0) begin
							ptr_q <= '0;
						end else begin
							ptr_q <= k_q;
						end
						state_q <= ST_EMIT;
					end else begin
						k_q <= KW'(k1);
						if (KW'(k1) == k_last) begin
							state_q <= ST_RLOAD;
						end else begin
							i_q     <= IW'(lo_next);
							i_hi_q  <= IW'(hi_next);
							state_q <= ST_PROD;
						end
					end
				end
				ST_EMIT: begin
					if (ptr_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q - 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath: operand capture, digit stores, column accumulators
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					mag_b_q <= sat_b;
					neg_q   <= (sign_a ^ sign_b) && (sat_a != '0) && (sat_b != '0);
				end
			end
			ST_CONV: begin
				if (conv_b_q) begin
					db_q[cnt_q[IW-1:0]] <= div_rem;
				end else begin
					da_q[cnt_q[IW-1:0]] <= div_rem;
				end
				acc_cur_q  <= '0;
				acc_next_q <= '0;
				carry_q    <= '0;
			end
			ST_PROD: begin
				acc_cur_q  <= acc_cur_add;
				acc_next_q <= acc_next_add;
			end
			ST_RES: begin
				carry_q    <= ACC_W'(div_quo);
				acc_cur_q  <= acc_next_q;
				acc_next_q <= '0;
			end
			default: begin
			end
		endcase
	end

	// Result memory: write resolved column digits, read them back most significant first
	always_ff @(posedge clk) begin
		if (state_q == ST_RES) begin
			res_mem[k_q] <= div_rem;
		end
		if (state_q == ST_EMIT) begin
			rd_q   <= res_mem[ptr_q];
			last_q <= (ptr_q == '0);
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign strobe     = strobe_q;
	assign digit      = rd_q;
	assign negative   = neg_q;
	assign last_digit = last_q;

	// A word that is not the last is followed by another word in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_digit |=> strobe)
		else $error("digit stream broke before the last word");

	// Every strobed digit is decimal
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (digit <= 4'd9))
		else $error("non-decimal digit delivered");

	// An accepted operation raises busy
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy did not rise after accept");

	// Column digits from the shared unit are decimal when resolved
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RES) |-> (div_rem <= 4'd9))
		else $error("column resolve produced a non-decimal digit");

endmodule
